>>> rtl/fca_pkg.sv
// ----------------------------------------------------------------------------
// fca_pkg: shared types and constants of the FAT chain allocator
// Table geometry, entry codes, opcodes, status codes, controller states and
// the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package fca_pkg;

   // Table geometry; TABLE_SIZE must be a power of two
   localparam int TABLE_SIZE = 4096;
   localparam int IDX_W      = $clog2(TABLE_SIZE);
   localparam int CNT_W      = $clog2(TABLE_SIZE + 1);

   // Field widths fixed by the interface
   localparam int ENTRY_W = 13;
   localparam int START_W = 12;
   localparam int OPC_W   = 3;
   localparam int FREED_W = 13;

   // Entry codes
   localparam logic signed [ENTRY_W-1:0] ENT_FREE = ENTRY_W'(-2);
   localparam logic signed [ENTRY_W-1:0] ENT_END  = ENTRY_W'(-1);

   typedef enum logic [OPC_W-1:0] {
      OP_READ   = 3'd0,
      OP_WRITE  = 3'd1,
      OP_ALLOC  = 3'd2,
      OP_APPEND = 3'd3,
      OP_FREE   = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      STS_OK      = 2'd0,
      STS_NOSPACE = 2'd1,
      STS_BAD     = 2'd2
   } sts_code_type;

   // Table write port source
   typedef enum logic [2:0] {
      WR_NONE,
      WR_VALUE,
      WR_LINK,
      WR_END,
      WR_FREE,
      WR_CLEAR
   } wr_sel_type;

   typedef enum logic [3:0] {
      CTL_CLEAR,
      CTL_IDLE,
      CTL_DECODE,
      CTL_READ_WAIT,
      CTL_APP_CHECK,
      CTL_SCAN,
      CTL_LINK,
      CTL_FILL_END,
      CTL_WALK_CHECK,
      CTL_WALK_READ,
      CTL_FINISH
   } ctl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic         load;
      logic         scan_init;
      logic         scan;
      wr_sel_type   wr_sel;
      logic         walk_adv;
      logic         set_rd_result;
      logic         set_found_result;
      logic         set_status;
      sts_code_type status_code;
      logic         rsp_load;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic             clr_last;
      logic [OPC_W-1:0] opcode;
      logic             idx_valid;
      logic             idx_is_end;
      logic             val_valid;
      logic             rd_free;
      logic             rd_end;
      logic             next_valid;
      logic             steps_full;
      logic             scan_hit;
      logic             scan_empty;
      logic             rsp_free;
   } dp_sts_type;

   function automatic logic is_valid_index(input logic signed [ENTRY_W-1:0] v);
      return (v >= 0) && (int'(v) < TABLE_SIZE);
   endfunction

endpackage

>>> rtl/fca_req_if.sv
// ----------------------------------------------------------------------------
// fca_req_if: request channel
// Carries one operation beat: opcode, block index and entry value.
// ----------------------------------------------------------------------------
interface fca_req_if import fca_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic [OPC_W-1:0]          opcode;
   logic signed [ENTRY_W-1:0] block_index;
   logic signed [ENTRY_W-1:0] entry_value;

   modport source (output valid, opcode, block_index, entry_value, input ready);
   modport sink   (input valid, opcode, block_index, entry_value, output ready);
endinterface

>>> rtl/fca_rsp_if.sv
// ----------------------------------------------------------------------------
// fca_rsp_if: response channel
// Carries one result beat: result value, freed count and status.
// ----------------------------------------------------------------------------
interface fca_rsp_if import fca_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic signed [ENTRY_W-1:0] result_value;
   logic [FREED_W-1:0]        freed_count;
   logic [1:0]                status;

   modport source (output valid, result_value, freed_count, status, input ready);
   modport sink   (input valid, result_value, freed_count, status, output ready);
endinterface

>>> rtl/fca_csr_if.sv
// ----------------------------------------------------------------------------
// fca_csr_if: configuration write channel
// Carries the search start index register write data.
// ----------------------------------------------------------------------------
interface fca_csr_if import fca_pkg::*;;
   logic               valid;
   logic               ready;
   logic [START_W-1:0] search_start;

   modport source (output valid, search_start, input ready);
   modport sink   (input valid, search_start, output ready);
endinterface

>>> rtl/fca_dp.sv
// ----------------------------------------------------------------------------
// fca_dp: allocator datapath
// Holds the allocation table memory, request registers, scan pipeline, chain
// walk registers and the response register. Acts on controller commands.
// ----------------------------------------------------------------------------
module fca_dp import fca_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  dp_cmd_type                cmd,
   output dp_sts_type                sts,
   input  logic [OPC_W-1:0]          req_opcode,
   input  logic signed [ENTRY_W-1:0] req_block_index,
   input  logic signed [ENTRY_W-1:0] req_entry_value,
   input  logic                      csr_we,
   input  logic [START_W-1:0]        csr_search_start,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic signed [ENTRY_W-1:0] rsp_result_value,
   output logic [FREED_W-1:0]        rsp_freed_count,
   output logic [1:0]                rsp_status
);

   logic signed [ENTRY_W-1:0] alloc_mem [TABLE_SIZE];

   logic [START_W-1:0]        search_start_ff;
   logic [IDX_W-1:0]          clr_addr_ff;
   logic [OPC_W-1:0]          opcode_ff;
   logic signed [ENTRY_W-1:0] index_ff;
   logic signed [ENTRY_W-1:0] value_ff;
   logic [IDX_W-1:0]          cur_ff;
   logic [CNT_W-1:0]          steps_ff;
   logic [CNT_W-1:0]          freed_ff;
   logic [CNT_W-1:0]          scan_addr_ff;
   logic                      pend_ff;
   logic [IDX_W-1:0]          pend_addr_ff;
   logic signed [ENTRY_W-1:0] rd_data_ff;
   logic signed [ENTRY_W-1:0] result_ff;
   sts_code_type              status_ff;
   logic                      rsp_valid_ff;
   logic signed [ENTRY_W-1:0] rsp_result_ff;
   logic [FREED_W-1:0]        rsp_freed_ff;
   logic [1:0]                rsp_status_ff;

   logic [IDX_W-1:0]          rd_addr;
   logic [IDX_W-1:0]          wr_addr;
   logic signed [ENTRY_W-1:0] wr_data;
   logic                      wr_en;
   logic                      scan_done;

   // Pick read address: scan pointer while scanning, else the current block
   assign rd_addr   = cmd.scan ? scan_addr_ff[IDX_W-1:0] : cur_ff;
   assign scan_done = (scan_addr_ff == CNT_W'(TABLE_SIZE));

   // Pick write address and data
   always_comb begin
      wr_en   = 1'b1;
      wr_addr = cur_ff;
      wr_data = ENT_FREE;
      case (cmd.wr_sel)
         WR_VALUE: wr_data = value_ff;
         WR_LINK:  wr_data = ENTRY_W'(pend_addr_ff);
         WR_END: begin
            wr_addr = pend_addr_ff;
            wr_data = ENT_END;
         end
         WR_FREE:  wr_data = ENT_FREE;
         WR_CLEAR: wr_addr = clr_addr_ff;
         default:  wr_en = 1'b0;
      endcase
   end

   // Table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         alloc_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= alloc_mem[rd_addr];
   end

   // Configuration register and clearing pass pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         search_start_ff <= '0;
         clr_addr_ff     <= '0;
      end else begin
         if (csr_we) begin
            search_start_ff <= csr_search_start;
         end
         if (cmd.wr_sel == WR_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
      end
   end

   // Capture request, advance chain walk
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         opcode_ff <= req_opcode;
         index_ff  <= req_block_index;
         value_ff  <= req_entry_value;
         cur_ff    <= req_block_index[IDX_W-1:0];
         steps_ff  <= '0;
         freed_ff  <= '0;
      end else if (cmd.walk_adv) begin
         cur_ff   <= rd_data_ff[IDX_W-1:0];
         steps_ff <= steps_ff + 1'b1;
         freed_ff <= freed_ff + 1'b1;
      end
   end

   // Scan pipeline: issue one read a cycle, tag it with its address
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else if (cmd.scan_init) begin
         pend_ff <= 1'b0;
      end else if (cmd.scan) begin
         pend_ff <= !scan_done;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         scan_addr_ff <= CNT_W'(search_start_ff);
      end else if (cmd.scan && !scan_done) begin
         scan_addr_ff <= scan_addr_ff + 1'b1;
         pend_addr_ff <= scan_addr_ff[IDX_W-1:0];
      end
   end

   // Build result fields
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         result_ff <= ENT_END;
         status_ff <= STS_OK;
      end else begin
         if (cmd.set_rd_result) begin
            result_ff <= rd_data_ff;
         end
         if (cmd.set_found_result) begin
            result_ff <= ENTRY_W'(pend_addr_ff);
         end
         if (cmd.set_status) begin
            status_ff <= cmd.status_code;
         end
      end
   end

   // Response register: hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_result_ff <= result_ff;
         rsp_freed_ff  <= FREED_W'(freed_ff);
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_result_ff;
   assign rsp_freed_count  = rsp_freed_ff;
   assign rsp_status       = rsp_status_ff;

   // Status back to the controller
   always_comb begin
      sts.clr_last   = (clr_addr_ff == {IDX_W{1'b1}});
      sts.opcode     = opcode_ff;
      sts.idx_valid  = is_valid_index(index_ff);
      sts.idx_is_end = (index_ff == ENT_END);
      sts.val_valid  = (value_ff == ENT_FREE) || (value_ff == ENT_END) ||
                       is_valid_index(value_ff);
      sts.rd_free    = (rd_data_ff == ENT_FREE);
      sts.rd_end     = (rd_data_ff == ENT_END);
      sts.next_valid = is_valid_index(rd_data_ff);
      sts.steps_full = (steps_ff == CNT_W'(TABLE_SIZE));
      sts.scan_hit   = pend_ff && (rd_data_ff == ENT_FREE);
      sts.scan_empty = !pend_ff && scan_done;
      sts.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

endmodule

>>> rtl/fca_ctrl.sv
// ----------------------------------------------------------------------------
// fca_ctrl: allocator controller
// Sequences the clearing pass, decodes each operation and steps the
// datapath through reads, free-block scans, chain walks and table writes.
// ----------------------------------------------------------------------------
module fca_ctrl import fca_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   ctl_state_type state_ff;
   ctl_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         CTL_CLEAR: begin
            cmd.wr_sel = WR_CLEAR;
            if (sts.clr_last) begin
               state_in = CTL_IDLE;
            end
         end
         CTL_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = CTL_DECODE;
            end
         end
         CTL_DECODE: begin
            state_in = CTL_FINISH;
            case (op_type'(sts.opcode))
               OP_READ: begin
                  if (sts.idx_valid) begin
                     state_in = CTL_READ_WAIT;
                  end else begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = STS_BAD;
                  end
               end
               OP_WRITE: begin
                  if (sts.idx_valid && sts.val_valid) begin
                     cmd.wr_sel = WR_VALUE;
                  end else begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = STS_BAD;
                  end
               end
               OP_ALLOC: begin
                  cmd.scan_init = 1'b1;
                  state_in      = CTL_SCAN;
               end
               OP_APPEND: begin
                  if (sts.idx_valid) begin
                     state_in = CTL_APP_CHECK;
                  end else begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = STS_BAD;
                  end
               end
               OP_FREE: begin
                  // empty chain finishes at once with ok
                  if (!sts.idx_is_end) begin
                     if (sts.idx_valid) begin
                        state_in = CTL_WALK_CHECK;
                     end else begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = STS_BAD;
                     end
                  end
               end
               default: begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = STS_BAD;
               end
            endcase
         end
         CTL_READ_WAIT: begin
            cmd.set_rd_result = 1'b1;
            state_in          = CTL_FINISH;
         end
         CTL_APP_CHECK: begin
            // appending after a free block is refused
            if (sts.rd_free) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = STS_BAD;
               state_in        = CTL_FINISH;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = CTL_SCAN;
            end
         end
         CTL_SCAN: begin
            if (sts.scan_hit) begin
               state_in = (op_type'(sts.opcode) == OP_APPEND) ? CTL_LINK : CTL_FILL_END;
            end else if (sts.scan_empty) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = STS_NOSPACE;
               state_in        = CTL_FINISH;
            end else begin
               cmd.scan = 1'b1;
            end
         end
         CTL_LINK: begin
            cmd.wr_sel = WR_LINK;
            state_in   = CTL_FILL_END;
         end
         CTL_FILL_END: begin
            cmd.wr_sel           = WR_END;
            cmd.set_found_result = 1'b1;
            state_in             = CTL_FINISH;
         end
         CTL_WALK_CHECK: begin
            if (sts.steps_full || sts.rd_free) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = STS_BAD;
               state_in        = CTL_FINISH;
            end else begin
               // free this block and follow its link
               cmd.wr_sel   = WR_FREE;
               cmd.walk_adv = 1'b1;
               if (sts.rd_end) begin
                  state_in = CTL_FINISH;
               end else if (!sts.next_valid) begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = STS_BAD;
                  state_in        = CTL_FINISH;
               end else begin
                  state_in = CTL_WALK_READ;
               end
            end
         end
         CTL_WALK_READ: begin
            state_in = CTL_WALK_CHECK;
         end
         CTL_FINISH: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = CTL_IDLE;
            end
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/fat_chain_allocator_top.sv
// ----------------------------------------------------------------------------
// fat_chain_allocator_top: FAT chain allocator
// Allocation table with read, write, head allocate, append and chain free.
//
//   channel | dir | beat contents
//   req_ch  | in  | opcode, block_index, entry_value
//   rsp_ch  | out | result_value, freed_count, status
//   csr_ch  | in  | search_start
//
// One operation at a time, one response beat per request beat. Allocate and
// append scan the table upward from search_start through the single table
// read port; chain free walks and frees the chain block by block. After
// reset a clearing pass writes all TABLE_SIZE (4096) entries free; no request
// is taken then. A pending response waits in its register while the next
// request is taken.
// ----------------------------------------------------------------------------
module fat_chain_allocator_top import fca_pkg::*;
(
   input logic      clock,
   input logic      reset,
   fca_req_if.sink  req_ch,
   fca_rsp_if.source rsp_ch,
   fca_csr_if.sink  csr_ch
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   // Configuration writes are always taken
   assign csr_ch.ready = 1'b1;

   fca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   fca_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_opcode       (req_ch.opcode),
      .req_block_index  (req_ch.block_index),
      .req_entry_value  (req_ch.entry_value),
      .csr_we           (csr_ch.valid),
      .csr_search_start (csr_ch.search_start),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_result_value (rsp_ch.result_value),
      .rsp_freed_count  (rsp_ch.freed_count),
      .rsp_status       (rsp_ch.status)
   );

   // Never overwrite a response that has not been taken
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> sts.rsp_free)
      else $error("response loaded over a pending beat");

   // One operation in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request taken while an operation is in flight");

   // Chain walk advances only while freeing the current block
   a_walk_frees: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_adv |-> (cmd.wr_sel == WR_FREE))
      else $error("chain walk advanced without freeing");

   // Scan stops as soon as a free entry is seen
   a_scan_stops: assert property (@(posedge clock) disable iff (reset)
      cmd.scan |-> !sts.scan_hit)
      else $error("scan advanced past a free entry");

endmodule

>>> dv/fca_tb_pkg.sv
// ----------------------------------------------------------------------------
// fca_tb_pkg: allocation table tracker for the FAT chain allocator bench
// Keeps a shadow of the allocation table and the search start, works out the
// response beat each accepted request beat should produce, and holds those
// beats in order until the block answers.
// ----------------------------------------------------------------------------
package fca_tb_pkg;
   import fca_pkg::*;

   typedef struct packed {
      logic signed [ENTRY_W-1:0] result_value;
      logic [FREED_W-1:0]        freed_count;
      sts_code_type              status;
   } fat_reply_type;

   class fat_table_tracker;
      logic signed [ENTRY_W-1:0] entries [TABLE_SIZE];
      logic [START_W-1:0]        scan_base;
      fat_reply_type             awaited [$];
      int                        faults;

      function new();
         foreach (entries[i]) entries[i] = ENT_FREE;
         scan_base = '0;
         faults    = 0;
      endfunction

      function void set_base(logic [START_W-1:0] v);
         scan_base = v;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function bit in_table(int v);
         return (v >= 0) && (v < TABLE_SIZE);
      endfunction

      // Lowest free entry at or above the search start, -1 when there is none
      function int first_free();
         for (int i = scan_base; i < TABLE_SIZE; i++) begin
            if (entries[i] == ENT_FREE) return i;
         end
         return -1;
      endfunction

      // Apply one operation to the shadow table and return its response beat
      function fat_reply_type table_outcome(logic [OPC_W-1:0] opc,
                                            logic signed [ENTRY_W-1:0] blk,
                                            logic signed [ENTRY_W-1:0] val);
         fat_reply_type r;
         int b;
         int v;
         int nb;
         int cur;
         int nxt;
         int steps;
         b = blk;
         v = val;
         r.result_value = ENT_END;
         r.freed_count  = '0;
         r.status       = STS_OK;
         case (opc)
            OP_READ: begin
               if (in_table(b)) r.result_value = entries[b];
               else r.status = STS_BAD;
            end
            OP_WRITE: begin
               if (in_table(b) && (val == ENT_FREE || val == ENT_END || in_table(v)))
                  entries[b] = val;
               else
                  r.status = STS_BAD;
            end
            OP_ALLOC: begin
               nb = first_free();
               if (nb < 0) begin
                  r.status = STS_NOSPACE;
               end else begin
                  entries[nb]    = ENT_END;
                  r.result_value = ENTRY_W'(nb);
               end
            end
            OP_APPEND: begin
               if (!in_table(b) || entries[b] == ENT_FREE) begin
                  r.status = STS_BAD;
               end else begin
                  nb = first_free();
                  if (nb < 0) begin
                     r.status = STS_NOSPACE;
                  end else begin
                     entries[b]     = ENTRY_W'(nb);
                     entries[nb]    = ENT_END;
                     r.result_value = ENTRY_W'(nb);
                  end
               end
            end
            OP_FREE: begin
               if (blk == ENT_END) begin
                  // empty chain: nothing to release
               end else if (!in_table(b)) begin
                  r.status = STS_BAD;
               end else begin
                  // walk the chain, releasing each block until end or breakage
                  cur   = b;
                  steps = 0;
                  forever begin
                     if (steps >= TABLE_SIZE || entries[cur] == ENT_FREE) begin
                        r.status = STS_BAD;
                        break;
                     end
                     steps++;
                     nxt          = entries[cur];
                     entries[cur] = ENT_FREE;
                     r.freed_count = r.freed_count + 1'b1;
                     if (nxt == -1) break;
                     if (!in_table(nxt)) begin
                        r.status = STS_BAD;
                        break;
                     end
                     cur = nxt;
                  end
               end
            end
            default: r.status = STS_BAD;
         endcase
         return r;
      endfunction

      // Note an accepted request beat and queue its response
      function fat_reply_type take_request(logic [OPC_W-1:0] opc,
                                           logic signed [ENTRY_W-1:0] blk,
                                           logic signed [ENTRY_W-1:0] val);
         fat_reply_type r;
         r = table_outcome(opc, blk, val);
         awaited.push_back(r);
         return r;
      endfunction

      // Compare an accepted response beat with the oldest queued one
      function void check_reply(logic signed [ENTRY_W-1:0] rv,
                                logic [FREED_W-1:0] fc,
                                logic [1:0] st);
         fat_reply_type e;
         if (awaited.size() == 0) begin
            $error("response beat with none outstanding: result_value %0d", rv);
            faults++;
            return;
         end
         e = awaited.pop_front();
         if (rv !== e.result_value) begin
            $error("result_value: expected %0d, got %0d", e.result_value, rv);
            faults++;
         end
         if (fc !== e.freed_count) begin
            $error("freed_count: expected %0d, got %0d", e.freed_count, fc);
            faults++;
         end
         if (st !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, st);
            faults++;
         end
      endfunction
   endclass

endpackage

>>> dv/tb_fat_chain_allocator_top.sv
// ----------------------------------------------------------------------------
// tb_fat_chain_allocator_top: bench for the FAT chain allocator
// Drives directed corner cases, then phases of random chain building and
// freeing mixed with table noise under several search starts, with random
// stalls on both channels; every response beat is checked against a shadow
// table kept by the tracker.
// ----------------------------------------------------------------------------
module tb_fat_chain_allocator_top import fca_pkg::*, fca_tb_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [OPC_W-1:0] OPC_SPARE_FIRST = 3'd5;
   localparam logic [OPC_W-1:0] OPC_SPARE_LAST  = 3'd7;
   localparam int               PHASE_ITEMS     = 28;

   typedef struct {
      int head;
      int tail;
   } chain_type;

   logic clock;
   logic reset;

   fca_req_if req_bus ();
   fca_rsp_if rsp_bus ();
   fca_csr_if csr_bus ();

   fat_table_tracker tracker = new();
   fat_reply_type    last_reply;
   chain_type        chains [$];
   bit               no_gaps;
   int               rsp_hold;

   fat_chain_allocator_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [ENTRY_W-1:0] any_word();
      logic signed [ENTRY_W-1:0] w;
      w = ENTRY_W'($urandom);
      return w;
   endfunction

   // Send one request beat and hand it to the tracker once accepted
   task automatic issue(input logic [OPC_W-1:0] opc, input int blk, input int val);
      int gap;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
      end
      @(negedge clock);
      req_bus.opcode      = opc;
      req_bus.block_index = ENTRY_W'(blk);
      req_bus.entry_value = ENTRY_W'(val);
      req_bus.valid       = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      last_reply = tracker.take_request(opc, req_bus.block_index, req_bus.entry_value);
   endtask

   // Hold the request side until every outstanding response has arrived
   task automatic settle();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (tracker.pending() > 0) @(posedge clock);
   endtask

   task automatic write_start(input logic [START_W-1:0] v);
      settle();
      @(negedge clock);
      csr_bus.search_start = v;
      csr_bus.valid        = 1'b1;
      do @(posedge clock); while (!csr_bus.ready);
      tracker.set_base(v);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // One random beat: mostly chain building and freeing, the rest noise
   task automatic rand_item();
      int r;
      int k;
      int blk;
      int val;
      r = $urandom_range(0, 99);
      if (r < 68) begin
         if (chains.size() == 0 || (r < 22 && chains.size() < 10)) begin
            issue(OP_ALLOC, any_word(), any_word());
            if (last_reply.status == STS_OK)
               chains.push_back('{last_reply.result_value, last_reply.result_value});
         end else if (r < 55) begin
            k = $urandom_range(0, chains.size() - 1);
            issue(OP_APPEND, chains[k].tail, any_word());
            if (last_reply.status == STS_OK) chains[k].tail = last_reply.result_value;
            else if (last_reply.status == STS_BAD) chains.delete(k);
         end else begin
            k = $urandom_range(0, chains.size() - 1);
            issue(OP_FREE, chains[k].head, any_word());
            chains.delete(k);
         end
      end else if (r < 80) begin
         if (r < 76 && chains.size() > 0)
            blk = chains[$urandom_range(0, chains.size() - 1)].tail;
         else
            blk = any_word();
         issue(OP_READ, blk, any_word());
      end else if (r < 90) begin
         blk = ($urandom_range(0, 3) == 0) ? any_word() : $urandom_range(2048, TABLE_SIZE - 1);
         case ($urandom_range(0, 3))
            0:       val = ENT_FREE;
            1:       val = ENT_END;
            2:       val = $urandom_range(0, TABLE_SIZE - 1);
            default: val = any_word();
         endcase
         issue(OP_WRITE, blk, val);
      end else if (r < 96) begin
         blk = $urandom_range(0, 1) ? ENT_END : any_word();
         issue(OP_FREE, blk, any_word());
      end else if (r < 98) begin
         issue(OP_APPEND, any_word(), any_word());
      end else begin
         issue(OPC_W'($urandom_range(OPC_SPARE_FIRST, OPC_SPARE_LAST)), any_word(),
               any_word());
      end
   endtask

   // Response side: check each accepted beat, then stall at random
   initial begin
      rsp_bus.ready = 1'b0;
      rsp_hold      = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            tracker.check_reply(rsp_bus.result_value, rsp_bus.freed_count, rsp_bus.status);
            rsp_hold = pick_gap();
         end
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_bus.ready = 1'b0;
            rsp_hold--;
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   // Abandon a hung run
   initial begin
      #60_000_000;
      $display("tb_fat_chain_allocator_top: errors");
      $finish;
   end

   initial begin
      req_bus.valid        = 1'b0;
      req_bus.opcode       = '0;
      req_bus.block_index  = '0;
      req_bus.entry_value  = '0;
      csr_bus.valid        = 1'b0;
      csr_bus.search_start = '0;
      no_gaps              = 1'b0;
      reset                = 1'b1;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // Directed: reads at the table edges and bad indices
      write_start('0);
      issue(OP_READ, 0, 0);
      issue(OP_READ, TABLE_SIZE - 1, 0);
      issue(OP_READ, ENT_END, 0);
      issue(OP_READ, -4096, -4096);

      // Build a short chain, then try appending after a free and a bad block
      issue(OP_ALLOC, 0, 0);
      issue(OP_APPEND, 0, 0);
      issue(OP_APPEND, 1, 0);
      issue(OP_APPEND, 100, 0);
      issue(OP_APPEND, ENT_END, 0);

      // Table loading, bad values and indices, freeing by write, a self loop
      issue(OP_WRITE, 10, TABLE_SIZE - 1);
      issue(OP_WRITE, TABLE_SIZE - 1, ENT_END);
      issue(OP_WRITE, 11, -3);
      issue(OP_WRITE, ENT_FREE, ENT_END);
      issue(OP_WRITE, 10, ENT_FREE);
      issue(OP_WRITE, 7, 7);
      issue(OP_READ, 1, 0);

      // Chain frees: good, empty, bad head, free head, looping chain
      issue(OP_FREE, 0, 0);
      issue(OP_FREE, ENT_END, 0);
      issue(OP_FREE, -5, 0);
      issue(OP_FREE, 50, 0);
      issue(OP_FREE, 7, 0);
      issue(OPC_SPARE_FIRST, 0, 0);
      issue(OPC_SPARE_LAST, -4096, -4096);

      // Search start at the top: the last entry is taken, so no space
      write_start({START_W{1'b1}});
      issue(OP_ALLOC, 0, 0);
      issue(OP_FREE, TABLE_SIZE - 1, 0);
      issue(OP_ALLOC, 0, 0);
      issue(OP_APPEND, TABLE_SIZE - 1, 0);
      issue(OP_WRITE, TABLE_SIZE - 1, ENT_FREE);

      // Random phases under different search starts
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0:       write_start('0);
            1:       write_start(START_W'($urandom_range(1, TABLE_SIZE - 2)));
            2:       write_start(START_W'($urandom_range(TABLE_SIZE - 16, TABLE_SIZE - 2)));
            default: write_start('0);
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            no_gaps = (n >= 12 && n < 22);
            rand_item();
         end
         no_gaps = 1'b0;
      end

      // Drain and let the block go quiet
      settle();
      repeat (50) @(posedge clock);
      if (tracker.faults == 0 && tracker.pending() == 0) begin
         $display("tb_fat_chain_allocator_top: clean");
      end else begin
         if (tracker.pending() != 0)
            $error("%0d response beats never arrived", tracker.pending());
         $display("tb_fat_chain_allocator_top: errors");
      end
      $finish;
   end

endmodule
